### rtl/core/sdht_pkg.sv
// Shared types and constants for the scheduled dual hysteresis thermostat.
package sdht_pkg;

  // Week schedule geometry
  localparam int HOURS_PER_DAY   = 24;
  localparam int WEEK_HOURS      = 168;
  localparam int SCHED_WORD_W    = 56;
  localparam int WEEK_IDX_W      = 8;
  localparam int LAST_DAY        = 6;
  localparam int LAST_HOUR       = 23;

  // Field widths
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = SCHED_WORD_W;
  localparam int TANK_SET_W      = 7;
  localparam int TANK_BAND_W     = 6;
  localparam int ROOM_SET_W      = 15;
  localparam int ROOM_BAND_W     = 11;
  localparam int DAY_W           = 3;
  localparam int HOUR_W          = 5;
  localparam int TANK_TEMP_W     = 9;
  localparam int ROOM_TEMP_W     = 15;
  localparam int MODE_W          = 2;
  // Widths of the threshold sums, one bit of headroom over the operands
  localparam int TANK_CMP_W      = 10;
  localparam int ROOM_CMP_W      = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TANK_SETPOINT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TANK_BAND     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROOM_SETPOINT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROOM_BAND     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCHED_LOW     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCHED_MID     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCHED_HIGH    = 3'd6;

  // Operation codes
  localparam logic OP_EVALUATE = 1'b0;
  localparam logic OP_SET_MODE = 1'b1;

  // Hot water modes
  localparam logic [MODE_W-1:0] MODE_SCHEDULE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ON       = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OFF      = 2'd3;

  // Reset values of the configuration registers
  localparam logic [TANK_SET_W-1:0]         TANK_SET_RST  = 7'd40;
  localparam logic [TANK_BAND_W-1:0]        TANK_BAND_RST = 6'd4;
  localparam logic signed [ROOM_SET_W-1:0]  ROOM_SET_RST  = 15'sd500;
  localparam logic [ROOM_BAND_W-1:0]        ROOM_BAND_RST = 11'd20;
  localparam logic [SCHED_WORD_W-1:0]       SCHED_RST     = {SCHED_WORD_W{1'b1}};

  typedef struct packed {
    logic [TANK_SET_W-1:0]        tank_setpoint;
    logic [TANK_BAND_W-1:0]       tank_band;
    logic signed [ROOM_SET_W-1:0] room_setpoint;
    logic [ROOM_BAND_W-1:0]       room_band;
    logic [WEEK_HOURS-1:0]        schedule;
  } cfg_t;

  typedef struct packed {
    logic                          operation;
    logic [DAY_W-1:0]              day_of_week;
    logic [HOUR_W-1:0]             hour_of_day;
    logic signed [TANK_TEMP_W-1:0] tank_temperature;
    logic signed [ROOM_TEMP_W-1:0] room_temperature;
    logic [MODE_W-1:0]             new_mode;
  } item_t;

  typedef struct packed {
    logic              water_demand;
    logic              heat_demand;
    logic              auto_active;
    logic              last_schedule_bit;
    logic [MODE_W-1:0] water_mode;
  } state_t;

  typedef struct packed {
    logic              heater_on;
    logic              water_heat_on;
    logic              heater_changed;
    logic [MODE_W-1:0] mode_now;
    logic              auto_program;
  } result_t;

endpackage

### rtl/core/scheduled_dual_hysteresis_thermostat.sv
// Top level: input register, control step, result register and state.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  operation .. new_mode
//   out      output     out_valid/ out_stall heater_on .. auto_program
//   cfg      input      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// One item per cycle unless a stall holds it; each item is held in the input
// register and its result moves into the result register when that has room.
// The step logic between them reads and updates the control state in one pass.
// Reset (rst, synchronous) empties both registers and loads the reset state.
// A stalled result holds; the input register still takes an item while empty.
module scheduled_dual_hysteresis_thermostat import sdht_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [DAY_W-1:0]              day_of_week,
  input  logic [HOUR_W-1:0]             hour_of_day,
  input  logic signed [TANK_TEMP_W-1:0] tank_temperature,
  input  logic signed [ROOM_TEMP_W-1:0] room_temperature,
  input  logic [MODE_W-1:0]             new_mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          heater_on,
  output logic                          water_heat_on,
  output logic                          heater_changed,
  output logic [MODE_W-1:0]             mode_now,
  output logic                          auto_program,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  state_t  state;
  state_t  state_next;
  result_t step_result;
  result_t result;
  logic    out_free;
  logic    advance;

  assign cfg_ready = 1'b1;

  sdht_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Move the held item on when the result register has room
  assign out_free = !out_valid || !out_stall;
  assign advance  = item_valid && out_free;
  assign in_stall = item_valid && !out_free;

  // Hold the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.operation        <= operation;
      item.day_of_week      <= day_of_week;
      item.hour_of_day      <= hour_of_day;
      item.tank_temperature <= tank_temperature;
      item.room_temperature <= room_temperature;
      item.new_mode         <= new_mode;
    end
  end

  sdht_step u_step (
    .cfg        (cfg),
    .item       (item),
    .state      (state),
    .state_next (state_next),
    .result     (step_result)
  );

  // Commit the control state as each item passes
  always_ff @(posedge clk) begin
    if (rst) begin
      state.water_demand      <= 1'b0;
      state.heat_demand       <= 1'b0;
      state.auto_active       <= 1'b0;
      state.last_schedule_bit <= 1'b1;
      state.water_mode        <= MODE_OFF;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign heater_on      = result.heater_on;
  assign water_heat_on  = result.water_heat_on;
  assign heater_changed = result.heater_changed;
  assign mode_now       = result.mode_now;
  assign auto_program   = result.auto_program;

endmodule

### rtl/core/sdht_cfg.sv
// Configuration register bank: setpoints, bands and the weekly schedule.
module sdht_cfg import sdht_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                   cfg
);

  logic [TANK_SET_W-1:0]        tank_setpoint;
  logic [TANK_BAND_W-1:0]       tank_band;
  logic signed [ROOM_SET_W-1:0] room_setpoint;
  logic [ROOM_BAND_W-1:0]       room_band;
  logic [SCHED_WORD_W-1:0]      sched_low;
  logic [SCHED_WORD_W-1:0]      sched_mid;
  logic [SCHED_WORD_W-1:0]      sched_high;

  // Load the addressed register; writes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      tank_setpoint <= TANK_SET_RST;
      tank_band     <= TANK_BAND_RST;
      room_setpoint <= ROOM_SET_RST;
      room_band     <= ROOM_BAND_RST;
      sched_low     <= SCHED_RST;
      sched_mid     <= SCHED_RST;
      sched_high    <= SCHED_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_TANK_SETPOINT: tank_setpoint <= wr_data[TANK_SET_W-1:0];
        CFG_TANK_BAND:     tank_band     <= wr_data[TANK_BAND_W-1:0];
        CFG_ROOM_SETPOINT: room_setpoint <= wr_data[ROOM_SET_W-1:0];
        CFG_ROOM_BAND:     room_band     <= wr_data[ROOM_BAND_W-1:0];
        CFG_SCHED_LOW:     sched_low     <= wr_data;
        CFG_SCHED_MID:     sched_mid     <= wr_data;
        CFG_SCHED_HIGH:    sched_high    <= wr_data;
        default: ;
      endcase
    end
  end

  // Present the registers, with the schedule as one week-hour vector
  assign cfg = '{
    tank_setpoint: tank_setpoint,
    tank_band:     tank_band,
    room_setpoint: room_setpoint,
    room_band:     room_band,
    schedule:      {sched_high, sched_mid, sched_low}
  };

endmodule

### rtl/core/sdht_step.sv
// Control step: schedule edge, hot water and room hysteresis for one item.
module sdht_step import sdht_pkg::*; (
  input  cfg_t    cfg,
  input  item_t   item,
  input  state_t  state,
  output state_t  state_next,
  output result_t result
);

  logic [WEEK_IDX_W-1:0]        week_hour;
  logic                         time_ok;
  logic                         sched_bit;
  logic                         water_en;
  logic                         changed;
  logic signed [TANK_CMP_W-1:0] tank_t;
  logic signed [TANK_CMP_W-1:0] tank_lo;
  logic signed [TANK_CMP_W-1:0] tank_hi;
  logic signed [ROOM_CMP_W-1:0] room_t;
  logic signed [ROOM_CMP_W-1:0] room_lo;
  logic signed [ROOM_CMP_W-1:0] room_hi;

  // Locate the week hour and read its schedule bit
  assign week_hour = WEEK_IDX_W'(item.day_of_week) * WEEK_IDX_W'(HOURS_PER_DAY)
                   + WEEK_IDX_W'(item.hour_of_day);
  assign time_ok   = (item.day_of_week <= DAY_W'(LAST_DAY))
                  && (item.hour_of_day <= HOUR_W'(LAST_HOUR));
  assign sched_bit = cfg.schedule[week_hour];

  // Build hysteresis thresholds
  assign tank_t  = TANK_CMP_W'(item.tank_temperature);
  assign tank_lo = $signed({3'b000, cfg.tank_setpoint}) - $signed({4'b0000, cfg.tank_band});
  assign tank_hi = $signed({3'b000, cfg.tank_setpoint}) + $signed({4'b0000, cfg.tank_band});
  assign room_t  = ROOM_CMP_W'(item.room_temperature);
  assign room_lo = ROOM_CMP_W'(cfg.room_setpoint) - $signed({5'b00000, cfg.room_band});
  assign room_hi = ROOM_CMP_W'(cfg.room_setpoint) + $signed({5'b00000, cfg.room_band});

  // Advance the state
  always_comb begin
    state_next = state;
    changed    = 1'b0;
    water_en   = 1'b0;
    if (item.operation == OP_SET_MODE) begin
      state_next.water_mode = item.new_mode;
    end else begin
      // Schedule edge sets or clears auto program and drops the one-shot mode
      if (time_ok) begin
        if (sched_bit != state.last_schedule_bit) begin
          state_next.auto_active       = sched_bit;
          state_next.last_schedule_bit = sched_bit;
          if (state.water_mode == MODE_ONCE) begin
            state_next.water_mode = MODE_SCHEDULE;
          end
        end
      end

      water_en = (state_next.auto_active || state_next.water_mode == MODE_ONCE
                  || state_next.water_mode == MODE_ON)
              && (state_next.water_mode != MODE_OFF);
      if (!water_en) begin
        state_next.water_demand = 1'b0;
      end else if (!state.water_demand && (tank_t < tank_lo)) begin
        state_next.water_demand = 1'b1;
      end else if (state.water_demand && (tank_t > tank_hi)) begin
        state_next.water_demand = 1'b0;
      end

      if (state.heat_demand && (room_hi < room_t)) begin
        state_next.heat_demand = 1'b0;
        changed                = 1'b1;
      end else if (!state.heat_demand && (room_t < room_lo)) begin
        state_next.heat_demand = 1'b1;
        changed                = 1'b1;
      end
    end
  end

  // Report the state after this step
  assign result.heater_on      = state_next.heat_demand;
  assign result.water_heat_on  = state_next.water_demand;
  assign result.heater_changed = changed;
  assign result.mode_now       = state_next.water_mode;
  assign result.auto_program   = state_next.auto_active;

endmodule
